@@ hw/rtl/brs_pkg.sv @@
// shared types and constants for the balanced range splitter
package brs_pkg;

    localparam int MAXS_W    = 7;
    localparam int MINS_W    = 32;
    localparam int MIN_SPLIT = 2;

    typedef enum logic [0:0] {
        CFG_MAX_SEGMENTS     = 1'b0,
        CFG_MIN_SEGMENT_SIZE = 1'b1
    } brs_cfg_idx_t;

    typedef struct packed {
        logic not_split;
        logic use_max;
    } brs_class_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ONE,
        B_START_N,
        B_WAIT_N,
        B_START_S,
        B_WAIT_S,
        B_EMIT
    } brs_state_t;

endpackage

@@ hw/rtl/balanced_range_splitter_unit.sv @@
// balanced range splitter top level: configuration registers and stream ports
// the back end takes a new request only once it has loaded the last segment of the one before;
// split requests use one serial divider, shared by the segment-count and share divisions
// reset: synchronous, clears control state; max_segments to 0, min_segment_size to 1
module balanced_range_splitter_unit import brs_pkg::*; #(
    parameter int COUNT_WIDTH = 32,
    parameter int MAX_SPLITS  = 64,
    localparam int IW         = $clog2(MAX_SPLITS),
    localparam int IN_W       = ((2 * COUNT_WIDTH + 7) / 8) * 8,
    localparam int OUT_W      = ((2 * COUNT_WIDTH + IW + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // base_offset, population
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // seg_offset, seg_size, seg_index
    output logic              m_tuser,   // not_split
    output logic              m_tlast,
    input  logic              cfg_we,
    input  brs_cfg_idx_t      cfg_index,
    input  logic [MINS_W-1:0] cfg_wdata
);

    localparam int NW = $clog2(MAX_SPLITS + 1);
    localparam int QW = 2 * COUNT_WIDTH + 2 + NW;

    logic [MAXS_W-1:0]      max_seg_reg;
    logic [MINS_W-1:0]      min_size_reg;
    logic                   q_in_valid;
    logic                   q_in_ready;
    logic [QW-1:0]          q_in_data;
    logic                   q_out_valid;
    logic                   q_out_ready;
    logic [QW-1:0]          q_out_data;
    logic [COUNT_WIDTH-1:0] seg_offset;
    logic [COUNT_WIDTH-1:0] seg_size;
    logic [IW-1:0]          seg_index;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_seg_reg  <= '0;
            min_size_reg <= MINS_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MAX_SEGMENTS:     max_seg_reg  <= cfg_wdata[MAXS_W-1:0];
                CFG_MIN_SEGMENT_SIZE: min_size_reg <= cfg_wdata;
                default:              max_seg_reg  <= max_seg_reg;
            endcase
        end
    end

    brs_front #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .MAX_SPLITS  (MAX_SPLITS),
        .NW          (NW),
        .QW          (QW)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_offset    (s_tdata[COUNT_WIDTH-1:0]),
        .in_pop       (s_tdata[2*COUNT_WIDTH-1:COUNT_WIDTH]),
        .max_segments (max_seg_reg),
        .min_size     (min_size_reg),
        .q_valid      (q_in_valid),
        .q_ready      (q_in_ready),
        .q_data       (q_in_data)
    );

    brs_queue #(
        .W (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_data   (q_in_data),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_data  (q_out_data)
    );

    brs_back #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .MAX_SPLITS  (MAX_SPLITS),
        .NW          (NW),
        .IW          (IW),
        .QW          (QW)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_out_valid),
        .q_ready     (q_out_ready),
        .q_data      (q_out_data),
        .min_size    (min_size_reg),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_offset    (seg_offset),
        .m_size      (seg_size),
        .m_index     (seg_index),
        .m_not_split (m_tuser),
        .m_last      (m_tlast)
    );

    assign m_tdata = OUT_W'({seg_index, seg_size, seg_offset});

endmodule

@@ hw/rtl/brs_front.sv @@
// front end: takes requests and classifies them as split or unsplit
module brs_front import brs_pkg::*; #(
    parameter int COUNT_WIDTH = 32,
    parameter int MAX_SPLITS  = 64,
    parameter int NW          = $clog2(MAX_SPLITS + 1),
    parameter int QW          = 2 * COUNT_WIDTH + 2 + NW
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [COUNT_WIDTH-1:0] in_offset,
    input  logic [COUNT_WIDTH-1:0] in_pop,
    input  logic [MAXS_W-1:0]      max_segments,
    input  logic [MINS_W-1:0]      min_size,
    output logic                   q_valid,
    input  logic                   q_ready,
    output logic [QW-1:0]          q_data
);

    localparam int PROD_W = MINS_W + NW;
    localparam int CMP_W  = ((COUNT_WIDTH > PROD_W) ? COUNT_WIDTH : PROD_W) + 2;

    logic                   s1_valid_reg;
    logic [COUNT_WIDTH-1:0] s1_off_reg;
    logic [COUNT_WIDTH-1:0] s1_pop_reg;
    logic [NW-1:0]          s1_maxs_reg;
    logic [PROD_W-1:0]      s1_prod_reg;
    logic [MINS_W:0]        s1_twomin_reg;
    logic [NW-1:0]          maxs_sat;
    logic                   accept;
    brs_class_t             cls;

    assign in_ready = !s1_valid_reg || q_ready;
    assign accept   = in_valid && in_ready;
    assign maxs_sat = (max_segments > MAXS_W'(MAX_SPLITS)) ? NW'(MAX_SPLITS)
                                                           : NW'(max_segments);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (q_ready) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_off_reg    <= in_offset;
            s1_pop_reg    <= in_pop;
            s1_maxs_reg   <= maxs_sat;
            s1_prod_reg   <= PROD_W'(min_size) * PROD_W'(maxs_sat);
            s1_twomin_reg <= {min_size, 1'b0};
        end
    end

    always_comb begin
        cls.not_split = (s1_maxs_reg < NW'(MIN_SPLIT)) ||
                        (CMP_W'(s1_pop_reg) < CMP_W'(s1_twomin_reg));
        cls.use_max   = CMP_W'(s1_pop_reg) >= CMP_W'(s1_prod_reg);
    end

    assign q_valid = s1_valid_reg;
    assign q_data  = {s1_maxs_reg, cls, s1_pop_reg, s1_off_reg};

endmodule

@@ hw/rtl/brs_queue.sv @@
// two-entry queue between front and back ends
module brs_queue #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);

    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic         push;
    logic         pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

@@ hw/rtl/brs_div.sv @@
// restoring divider, one quotient bit per cycle
module brs_div #(
    parameter int W = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     rem_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [W:0]       shifted;
    logic [W+1:0]     diff;
    logic [W-1:0]     rem_next;
    logic [W-1:0]     quo_next;

    always_comb begin
        shifted = {rem_reg, quo_reg[W-1]};
        diff    = {1'b0, shifted} - {2'b00, dvs_reg};
        if (diff[W+1]) begin
            rem_next = shifted[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b0};
        end else begin
            rem_next = diff[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ hw/rtl/brs_back.sv @@
// back end: works out segment count and share, then emits the segments, or one not_split result
module brs_back import brs_pkg::*; #(
    parameter int COUNT_WIDTH = 32,
    parameter int MAX_SPLITS  = 64,
    parameter int NW          = $clog2(MAX_SPLITS + 1),
    parameter int IW          = $clog2(MAX_SPLITS),
    parameter int QW          = 2 * COUNT_WIDTH + 2 + NW
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  logic [QW-1:0]          q_data,
    input  logic [MINS_W-1:0]      min_size,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [COUNT_WIDTH-1:0] m_offset,
    output logic [COUNT_WIDTH-1:0] m_size,
    output logic [IW-1:0]          m_index,
    output logic                   m_not_split,
    output logic                   m_last
);

    brs_state_t             state_reg;
    brs_state_t             state_next;
    logic [COUNT_WIDTH-1:0] off_reg;
    logic [COUNT_WIDTH-1:0] pop_reg;
    logic [NW-1:0]          n_reg;
    logic [COUNT_WIDTH-1:0] share_reg;
    logic [IW-1:0]          left_reg;
    logic [IW-1:0]          idx_reg;
    logic                   m_valid_reg;
    logic [COUNT_WIDTH-1:0] m_offset_reg;
    logic [COUNT_WIDTH-1:0] m_size_reg;
    logic [IW-1:0]          m_index_reg;
    logic                   m_ns_reg;
    logic                   m_last_reg;

    logic [COUNT_WIDTH-1:0] q_off;
    logic [COUNT_WIDTH-1:0] q_pop;
    brs_class_t             q_cls;
    logic [NW-1:0]          q_maxs;
    logic                   slot_free;
    logic                   div_start;
    logic                   div_sel_n;
    logic                   div_done;
    logic [COUNT_WIDTH-1:0] div_quo;
    logic [COUNT_WIDTH-1:0] div_rem;
    logic [COUNT_WIDTH-1:0] div_dvs;
    logic                   out_load;
    logic                   out_ns;
    logic [COUNT_WIDTH-1:0] seg_size;
    logic                   seg_last;

    assign q_off     = q_data[COUNT_WIDTH-1:0];
    assign q_pop     = q_data[2*COUNT_WIDTH-1:COUNT_WIDTH];
    assign q_cls     = brs_class_t'(q_data[2*COUNT_WIDTH+1:2*COUNT_WIDTH]);
    assign q_maxs    = q_data[QW-1:2*COUNT_WIDTH+2];
    assign slot_free = !m_valid_reg || m_ready;
    assign div_dvs   = div_sel_n ? COUNT_WIDTH'(min_size) : COUNT_WIDTH'(n_reg);
    assign seg_size  = share_reg + COUNT_WIDTH'(idx_reg < left_reg);
    assign seg_last  = (NW'(idx_reg) + NW'(1)) == n_reg;

    brs_div #(
        .W (COUNT_WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (pop_reg),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    if (q_cls.not_split) begin
                        state_next = B_ONE;
                    end else if (q_cls.use_max) begin
                        state_next = B_START_S;
                    end else begin
                        state_next = B_START_N;
                    end
                end
            end
            B_ONE: begin
                if (slot_free) begin
                    state_next = B_IDLE;
                end
            end
            B_START_N: state_next = B_WAIT_N;
            B_WAIT_N: begin
                if (div_done) begin
                    state_next = B_START_S;
                end
            end
            B_START_S: state_next = B_WAIT_S;
            B_WAIT_S: begin
                if (div_done) begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT: begin
                if (slot_free && seg_last) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb begin
        q_ready   = 1'b0;
        div_start = 1'b0;
        div_sel_n = 1'b0;
        out_load  = 1'b0;
        out_ns    = 1'b0;
        unique case (state_reg)
            B_IDLE:    q_ready = 1'b1;
            B_ONE: begin
                out_load = slot_free;
                out_ns   = 1'b1;
            end
            B_START_N: begin
                div_start = 1'b1;
                div_sel_n = 1'b1;
            end
            B_WAIT_N:  div_sel_n = 1'b1;
            B_START_S: div_start = 1'b1;
            B_WAIT_S:  div_start = 1'b0;
            B_EMIT:    out_load = slot_free;
            default:   q_ready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == B_IDLE && q_valid) begin
            off_reg <= q_off;
            pop_reg <= q_pop;
            n_reg   <= q_maxs;
        end
        if (state_reg == B_WAIT_N && div_done) begin
            n_reg <= div_quo[NW-1:0];
        end
        if (state_reg == B_WAIT_S && div_done) begin
            share_reg <= div_quo;
            left_reg  <= div_rem[IW-1:0];
            idx_reg   <= '0;
        end
        if (out_load) begin
            if (out_ns) begin
                m_offset_reg <= '0;
                m_size_reg   <= '0;
                m_index_reg  <= '0;
                m_ns_reg     <= 1'b1;
                m_last_reg   <= 1'b1;
            end else begin
                m_offset_reg <= off_reg;
                m_size_reg   <= seg_size;
                m_index_reg  <= idx_reg;
                m_ns_reg     <= 1'b0;
                m_last_reg   <= seg_last;
                off_reg      <= off_reg + seg_size;
                idx_reg      <= idx_reg + IW'(1);
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_offset    = m_offset_reg;
    assign m_size      = m_size_reg;
    assign m_index     = m_index_reg;
    assign m_not_split = m_ns_reg;
    assign m_last      = m_last_reg;

endmodule

@@ sim/balanced_range_splitter_unit_tb.sv @@
`timescale 1ns / 100ps
// testbench for the balanced range splitter: directed and random requests, scoreboard checks
module balanced_range_splitter_unit_tb;
    import brs_pkg::*;

    localparam int COUNT_W        = 32;
    localparam int SPLIT_CAP      = 64;
    localparam int IDX_W          = $clog2(SPLIT_CAP);
    localparam int IN_W           = ((2 * COUNT_W + 7) / 8) * 8;
    localparam int OUT_W          = ((2 * COUNT_W + IDX_W + 7) / 8) * 8;
    localparam int MAX_WAIT       = 17;
    localparam int SETTLE_CYCLES  = 150;
    localparam int HOLD_CYCLES    = 400;
    localparam int CYCLE_LIMIT    = 1500000;
    localparam int RANDOM_PHASES  = 7;
    localparam int PHASE_REQUESTS = 24;
    localparam int PRINT_LIMIT    = 50;

    typedef struct packed {
        logic [COUNT_W-1:0] start;
        logic [COUNT_W-1:0] length;
        logic [IDX_W-1:0]   position;
        logic               unsplit;
        logic               tail;
    } segment_t;

    class segment_ledger;
        logic [MAXS_W-1:0] max_segments;
        logic [MINS_W-1:0] min_size;
        segment_t          expected[$];
        int                mismatches;
        int                segments_checked;
        int                requests_noted;

        function new();
            max_segments     = '0;
            min_size         = 1;
            mismatches       = 0;
            segments_checked = 0;
            requests_noted   = 0;
        endfunction

        function void write_reg(brs_cfg_idx_t idx, logic [MINS_W-1:0] value);
            case (idx)
                CFG_MAX_SEGMENTS:     max_segments = value[MAXS_W-1:0];
                CFG_MIN_SEGMENT_SIZE: min_size = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected.size();
        endfunction

        // works out every segment that one accepted request should produce
        function void note_request(logic [COUNT_W-1:0] base, logic [COUNT_W-1:0] population);
            logic [MAXS_W-1:0]  cap;
            logic [COUNT_W-1:0] count;
            logic [COUNT_W-1:0] share;
            logic [COUNT_W-1:0] extra;
            logic [COUNT_W-1:0] offset;
            segment_t           seg;
            int                 k;
            requests_noted++;
            cap = (max_segments > SPLIT_CAP) ? MAXS_W'(SPLIT_CAP) : max_segments;
            if (cap < MIN_SPLIT || (population >> 1) < min_size) begin
                seg = '0;
                seg.unsplit = 1'b1;
                seg.tail = 1'b1;
                expected.insert(expected.size(), seg);
                return;
            end
            if (min_size == 0 || population / min_size >= cap)
                count = cap;
            else
                count = population / min_size;
            share  = population / count;
            extra  = population % count;
            offset = base;
            for (k = 0; k < count; k++) begin
                seg.start    = offset;
                seg.length   = share + ((k < extra) ? 1 : 0);
                seg.position = k[IDX_W-1:0];
                seg.unsplit  = 1'b0;
                seg.tail     = (k + 1 == count);
                expected.insert(expected.size(), seg);
                offset = offset + seg.length;
            end
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_segment(segment_t got);
            segment_t want;
            if (expected.size() == 0) begin
                report($sformatf("segment with nothing outstanding, start %h length %h",
                                 got.start, got.length));
                return;
            end
            want = expected.pop_front();
            segments_checked++;
            if (got.start !== want.start)
                report($sformatf("seg_offset %h, want %h", got.start, want.start));
            if (got.length !== want.length)
                report($sformatf("seg_size %h, want %h", got.length, want.length));
            if (got.position !== want.position)
                report($sformatf("seg_index %0d, want %0d", got.position, want.position));
            if (got.unsplit !== want.unsplit)
                report($sformatf("not_split %b, want %b", got.unsplit, want.unsplit));
            if (got.tail !== want.tail)
                report($sformatf("last %b, want %b", got.tail, want.tail));
        endtask
    endclass

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata   = '0;   // base_offset, population
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [OUT_W-1:0]  m_tdata;          // seg_offset, seg_size, seg_index
    logic              m_tuser;          // not_split
    logic              m_tlast;
    logic              cfg_we    = 1'b0;
    brs_cfg_idx_t      cfg_index = CFG_MAX_SEGMENTS;
    logic [MINS_W-1:0] cfg_wdata = '0;

    segment_ledger ledger;
    bit            quiet_phase    = 1'b0;
    bit            hold_requested = 1'b0;
    int            cycle_count    = 0;
    int            settings_used  = 0;

    balanced_range_splitter_unit DUT (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    task automatic configure(input logic [31:0] max_word, input logic [MINS_W-1:0] min_word);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_SEGMENTS;
        cfg_wdata <= max_word;
        @(posedge aclk);
        ledger.write_reg(CFG_MAX_SEGMENTS, max_word);
        cfg_index <= CFG_MIN_SEGMENT_SIZE;
        cfg_wdata <= min_word;
        @(posedge aclk);
        ledger.write_reg(CFG_MIN_SEGMENT_SIZE, min_word);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic send_request(input logic [COUNT_W-1:0] base,
                                input logic [COUNT_W-1:0] population);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({population, base});
        do @(posedge aclk); while (!s_tready);
        ledger.note_request(base, population);
    endtask

    task automatic drain();
        while (ledger.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_settings();
        logic [31:0] max_word;
        logic [31:0] min_word;
        case ($urandom_range(0, 7))
            0:       max_word = $urandom_range(0, 1);
            1:       max_word = $urandom_range(SPLIT_CAP + 1, 127);
            2:       max_word = SPLIT_CAP;
            default: max_word = $urandom_range(2, SPLIT_CAP);
        endcase
        // junk above the register width must be dropped
        if ($urandom_range(0, 3) == 0)
            max_word = max_word | ($urandom & 32'hFFFF_FF80);
        case ($urandom_range(0, 5))
            0:       min_word = 0;
            1:       min_word = $urandom;
            2:       min_word = 1;
            default: min_word = $urandom_range(1, 40);
        endcase
        configure(max_word, min_word);
    endtask

    task automatic random_request();
        logic [COUNT_W-1:0] base;
        logic [COUNT_W-1:0] population;
        logic [63:0]        wide;
        int                 cap;
        cap  = (ledger.max_segments > SPLIT_CAP) ? SPLIT_CAP : ledger.max_segments;
        base = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 300) : $urandom;
        case ($urandom_range(0, 5))
            0: population = $urandom;
            1: population = $urandom_range(0, 2 * cap + 3);
            default: begin
                // around min * max so both segment-count rules get hit
                wide = 64'(ledger.min_size) * $urandom_range(0, cap + 3) + $urandom_range(0, 7);
                population = (wide > 64'hFFFF_FFFF) ? $urandom : wide[31:0];
            end
        endcase
        send_request(base, population);
    endtask

    initial begin : result_sink
        int       pause;
        segment_t got;
        forever begin
            if (hold_requested) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_requested = 1'b0;
            end
            pause = quiet_phase ? 0 : $urandom_range(0, MAX_WAIT);
            if (pause > 0) begin
                m_tready <= 1'b0;
                repeat (pause) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got.start    = m_tdata[COUNT_W-1:0];
            got.length   = m_tdata[2*COUNT_W-1:COUNT_W];
            got.position = m_tdata[2*COUNT_W +: IDX_W];
            got.unsplit  = m_tuser;
            got.tail     = m_tlast;
            ledger.check_segment(got);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("balanced_range_splitter_unit_tb: FAIL");
        $finish;
    end

    initial begin : stimulus
        int p;
        ledger = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (5) @(posedge aclk);

        // limits straight out of reset never split
        send_request(32'h0000_0000, 32'h0000_0000);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        s_tvalid <= 1'b0;
        drain();

        configure(4, 1);
        send_request(32'h0000_0000, 32'h0000_0000);
        send_request(32'h0000_0005, 32'h0000_0001);
        send_request(32'h0000_0000, 32'h0000_0002);
        send_request(32'hFFFF_FFFE, 32'h0000_0007);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'h0000_0100, 32'h0000_000A);
        s_tvalid <= 1'b0;
        drain();

        // saturated maximum, zero minimum: empty ranges give empty segments
        hold_requested = 1'b1;
        configure(32'hFFFF_FF7F, 0);
        send_request(32'h0000_0000, 32'h0000_0000);
        send_request(32'h1234_5678, 32'h0000_003F);
        send_request(32'hFFFF_FF00, 32'hFFFF_FFFF);
        s_tvalid <= 1'b0;
        drain();

        configure(2, 32'h7FFF_FFFF);
        send_request(32'h8000_0000, 32'hFFFF_FFFF);
        send_request(32'h0000_0001, 32'hFFFF_FFFE);
        send_request(32'h0000_0000, 32'hFFFF_FFFD);
        s_tvalid <= 1'b0;
        drain();

        configure(SPLIT_CAP + 1, 32'hFFFF_FFFF);
        send_request(32'h0000_0000, 32'hFFFF_FFFF);
        send_request(32'hAAAA_AAAA, 32'h5555_5555);
        s_tvalid <= 1'b0;
        drain();

        configure(1, 0);
        send_request(32'h0000_0007, 32'h0000_03E8);
        s_tvalid <= 1'b0;
        drain();

        quiet_phase = 1'b1;
        configure(SPLIT_CAP, 3);
        send_request(32'h5555_5555, 32'h0000_0064);
        send_request(32'h0000_0000, 32'hAAAA_AAAA);
        s_tvalid <= 1'b0;
        drain();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            quiet_phase = (p % 3 == 1);
            if (p == 3)
                hold_requested = 1'b1;
            random_settings();
            repeat (PHASE_REQUESTS) random_request();
            s_tvalid <= 1'b0;
            drain();
        end

        $display("ran %0d requests under %0d limit settings, %0d segments compared",
                 ledger.requests_noted, settings_used, ledger.segments_checked);
        $display("%0d mismatches in %0d cycles", ledger.mismatches, cycle_count);
        if (ledger.mismatches == 0 && ledger.pending() == 0) begin
            $display("balanced_range_splitter_unit_tb: PASS");
        end else begin
            $display("balanced_range_splitter_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
